// File: hw/rtl/lbs_pkg.sv
// Shared types, constants and saturation helper for the skinning block.
`default_nettype none
package lbs_pkg;

   localparam int DATA_W      = 32;
   localparam int MAT_WORDS   = 12;
   localparam int BONES       = 4;
   localparam int WEIGHT_W    = 17;
   localparam int WEIGHT_FRAC = 16;
   localparam int BONE_W      = 8;
   localparam int ADDR_W      = 12;
   localparam int SLOT_W      = 9;
   localparam int ELEM_W      = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int REQ_TDATA_W = 336;
   localparam int RSP_TDATA_W = 192;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [SLOT_W-1:0] SLOT_WORLD  = 9'd256;
   localparam logic [SLOT_W-1:0] SLOT_NORMAL = 9'd257;
   // floor(addr/12) == (addr*2731) >> 15 for every 12-bit addr
   localparam logic [ADDR_W-1:0] DIV12_MUL   = 12'd2731;
   localparam int                DIV12_SHIFT = 15;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_VERTEX = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_SKIN_ENABLE = 1'b0,
      REG_NONE        = 1'b1
   } reg_index_type;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      logic                  vld;
      logic                  is_vtx;
      logic                  wr_world;
      logic                  wr_normal;
      logic [ELEM_W-1:0]     elem;
      logic [DATA_W-1:0]     value;
   } ctl_type;

   typedef struct packed {
      ctl_type                          ctl;
      logic                             wr_joint;
      logic                             skin;
      logic [SLOT_W-1:0]                slot;
      logic [2:0][DATA_W-1:0]           pos;
      logic [2:0][DATA_W-1:0]           nrm;
      logic [BONES-1:0][BONE_W-1:0]     bone;
      logic [BONES-1:0][WEIGHT_W-1:0]   weight;
      logic [BONES-1:0]                 use_bone;
   } item_type;

   function automatic word_type sat32(input logic signed [67:0] v);
      logic signed [67:0] max_v;
      logic signed [67:0] min_v;
      max_v = 68'sd2147483647;
      min_v = -68'sd2147483648;
      if (v > max_v) begin
         return 32'sh7FFFFFFF;
      end else if (v < min_v) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lbs_front.sv
// Front end: splits the request word into fields and classifies it.
`default_nettype none
module lbs_front
   import lbs_pkg::*;
#(
   parameter int JOINT_COUNT = 256
) (
   input  wire logic                   skin_enable,
   input  wire logic [REQ_TDATA_W-1:0] req_data,
   input  wire logic                   req_kind,
   output item_type                    item
);

   logic [ADDR_W-1:0]        addr;
   logic [2*ADDR_W-1:0]      div_prod;
   logic [SLOT_W-1:0]        slot;
   logic [SLOT_W+ELEM_W-1:0] slot_x12;
   logic                     is_vtx;
   logic [31:0]              bones;
   logic [33:0]              w_lo;
   logic [33:0]              w_hi;

   always_comb begin
      addr     = req_data[11:0];
      is_vtx   = (opcode_type'(req_kind) == OP_VERTEX);
      div_prod = addr * DIV12_MUL;
      slot     = div_prod[DIV12_SHIFT +: SLOT_W];
      slot_x12 = 13'(slot) * 13'd12;
      bones    = req_data[267:236];
      w_lo     = req_data[301:268];
      w_hi     = req_data[335:302];

      item.ctl.vld       = 1'b1;
      item.ctl.is_vtx    = is_vtx;
      item.ctl.elem      = ELEM_W'(13'(addr) - slot_x12);
      item.ctl.value     = req_data[43:12];
      item.ctl.wr_world  = !is_vtx && (slot == SLOT_WORLD);
      item.ctl.wr_normal = !is_vtx && (slot == SLOT_NORMAL);
      item.wr_joint      = !is_vtx && (slot < SLOT_W'(JOINT_COUNT));
      item.skin          = skin_enable;
      item.slot          = slot;
      for (int i = 0; i < 3; i++) begin
         item.pos[i] = req_data[44 + 32*i +: 32];
         item.nrm[i] = req_data[140 + 32*i +: 32];
      end
      item.weight[0] = w_lo[16:0];
      item.weight[1] = w_lo[33:17];
      item.weight[2] = w_hi[16:0];
      item.weight[3] = w_hi[33:17];
      for (int k = 0; k < BONES; k++) begin
         item.bone[k]     = bones[8*k +: 8];
         // drop bones when skinning is off, or with zero weight or an index past the joint table
         item.use_bone[k] = skin_enable && (item.weight[k] != '0)
                            && ({1'b0, item.bone[k]} < 9'(JOINT_COUNT));
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lbs_queue.sv
// Small word queue between the front end and the compute pipeline.
`default_nettype none
module lbs_queue
   import lbs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   output logic      full,
   input  wire logic pop,
   output logic      not_empty,
   output item_type  head_item
);

   item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   head_ff, head_in;
   logic [QPTR_W-1:0]   tail_ff, tail_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head_item = slots_ff[head_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      head_in   = do_pop ? head_ff + 1'b1 : head_ff;
      tail_in   = do_push ? tail_ff + 1'b1 : tail_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[tail_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lbs_blend.sv
// Joint matrix banks and the four-bone weighted blend pipeline.
`default_nettype none
module lbs_blend
   import lbs_pkg::*;
#(
   parameter int JOINT_COUNT = 256,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic en,
   input  wire logic in_valid,
   input  item_type  in_item,
   output ctl_type   out_ctl,
   output logic [2:0][DATA_W-1:0]         out_pos,
   output logic [2:0][DATA_W-1:0]         out_nrm,
   output logic [MAT_WORDS-1:0][DATA_W-1:0] out_mat
);

   localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

   ctl_type c1_ff, c2_ff, c3_ff, c4_ff;
   logic    s1_ff, s2_ff, s3_ff;
   logic [2:0][DATA_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic [2:0][DATA_W-1:0] n1_ff, n2_ff, n3_ff, n4_ff;
   logic [BONES-1:0][WEIGHT_W-1:0] w1_ff;
   logic [BONES-1:0]               u1_ff;
   logic signed [DATA_W-1:0] rd_ff   [BONES][MAT_WORDS];
   logic signed [49:0]       prod_ff [BONES][MAT_WORDS];
   logic signed [50:0]       pair_ff [MAT_WORDS][2];
   logic [MAT_WORDS-1:0][DATA_W-1:0] mat_ff;
   ctl_type in_ctl;

   always_comb begin
      in_ctl     = in_item.ctl;
      in_ctl.vld = in_valid;
   end

   // one bank per element and bone copy: each reads one joint a cycle while en is high
   for (genvar k = 0; k < BONES; k++) begin : g_bone
      for (genvar e = 0; e < MAT_WORDS; e++) begin : g_elem
         logic [DATA_W-1:0] mem [JOINT_COUNT];
         logic              we;
         assign we = in_valid && in_item.wr_joint && (in_item.ctl.elem == ELEM_W'(e));
         always_ff @(posedge clock) begin
            if (en) begin
               if (we) begin
                  mem[in_item.slot[JW-1:0]] <= in_item.ctl.value;
               end
               rd_ff[k][e] <= mem[in_item.bone[k][JW-1:0]];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
      end else if (en) begin
         c1_ff <= in_ctl;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= in_item.skin;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         w1_ff <= in_item.weight;
         u1_ff <= in_item.use_bone;
         p1_ff <= in_item.pos;
         n1_ff <= in_item.nrm;
         p2_ff <= p1_ff;
         n2_ff <= n1_ff;
         p3_ff <= p2_ff;
         n3_ff <= n2_ff;
         p4_ff <= p3_ff;
         n4_ff <= n3_ff;
         for (int k = 0; k < BONES; k++) begin
            for (int e = 0; e < MAT_WORDS; e++) begin
               prod_ff[k][e] <= u1_ff[k]
                  ? 50'(rd_ff[k][e]) * 50'($signed({1'b0, w1_ff[k]}))
                  : '0;
            end
         end
         for (int e = 0; e < MAT_WORDS; e++) begin
            pair_ff[e][0] <= 51'(prod_ff[0][e]) + 51'(prod_ff[1][e]);
            pair_ff[e][1] <= 51'(prod_ff[2][e]) + 51'(prod_ff[3][e]);
            if (s3_ff) begin
               mat_ff[e] <= sat32((68'(pair_ff[e][0]) + 68'(pair_ff[e][1]))
                                  >>> WEIGHT_FRAC);
            end else begin
               // identity passes the vertex through the skin transform unchanged
               mat_ff[e] <= (e == 0 || e == 4 || e == 8) ? ONE : '0;
            end
         end
      end
   end

   assign out_ctl = c4_ff;
   assign out_pos = p4_ff;
   assign out_nrm = n4_ff;
   assign out_mat = mat_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lbs_xform.sv
// Two-stage vector-by-matrix unit: affine for position, linear for normal.
`default_nettype none
module lbs_xform
   import lbs_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic en,
   input  wire logic [2:0][DATA_W-1:0]           vec_pos,
   input  wire logic [2:0][DATA_W-1:0]           vec_nrm,
   input  wire logic [MAT_WORDS-1:0][DATA_W-1:0] mat_pos,
   input  wire logic [MAT_WORDS-1:0][DATA_W-1:0] mat_nrm,
   output logic [2:0][DATA_W-1:0]                res_pos,
   output logic [2:0][DATA_W-1:0]                res_nrm
);

   logic signed [63:0] pp_ff [3][3];
   logic signed [63:0] np_ff [3][3];
   logic signed [DATA_W-1:0] tr_ff [3];
   logic [2:0][DATA_W-1:0] rp_ff, rn_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            tr_ff[c] <= mat_pos[9 + c];
            for (int r = 0; r < 3; r++) begin
               pp_ff[r][c] <= 64'($signed(vec_pos[r])) * 64'($signed(mat_pos[r*3 + c]));
               np_ff[r][c] <= 64'($signed(vec_nrm[r])) * 64'($signed(mat_nrm[r*3 + c]));
            end
         end
         for (int c = 0; c < 3; c++) begin
            rp_ff[c] <= sat32(68'(tr_ff[c])
                              + (68'(pp_ff[0][c]) >>> FRAC_BITS)
                              + (68'(pp_ff[1][c]) >>> FRAC_BITS)
                              + (68'(pp_ff[2][c]) >>> FRAC_BITS));
            rn_ff[c] <= sat32((68'(np_ff[0][c]) >>> FRAC_BITS)
                              + (68'(np_ff[1][c]) >>> FRAC_BITS)
                              + (68'(np_ff[2][c]) >>> FRAC_BITS));
         end
      end
   end

   assign res_pos = rp_ff;
   assign res_nrm = rn_ff;

endmodule
`default_nettype wire

// File: hw/rtl/linear_blend_skin_vertex.sv
// Top level of the four-bone skinning and world transform block.
// Streams one word per clock while not held by back-pressure: a load word
// in range writes one element of a joint, world or normal matrix; a vertex
// word returns the position and normal after optional four-bone blending
// and the world/normal transform, all in signed fixed point with FRAC_BITS
// fraction bits and saturated to 32 bits. Steady rate is one word per cycle
// in both directions while the result port is ready; a vertex word is
// written into the queue, then registered through the joint banks and blend
// adders and through each of the two transform units. Each of the 48 joint
// banks (4 bone copies x 12 elements) is read once and written at most once
// per cycle, which sets the rate.
// A four-entry queue lets the input keep taking words while the result port is
// stalled, until it fills. Matrix contents are undefined until loaded.
`default_nettype none
module linear_blend_skin_vertex
   import lbs_pkg::*;
#(
   parameter int JOINT_COUNT = 256,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: word_addr, word_value, pos_x, pos_y, pos_z, norm_x, norm_y,
   //            norm_z, bone_indices, weights_low, weights_high
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // req_tuser: opcode
   input  wire logic                   req_tuser,
   // rsp_tdata: out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y,
   //            out_norm_z
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic          skin_enable_ff;
   reg_index_type csr_reg;
   item_type      front_item;
   item_type      q_item;
   logic          q_full, q_valid;
   logic          en;
   ctl_type       bl_ctl;
   logic [2:0][DATA_W-1:0]           bl_pos, bl_nrm;
   logic [MAT_WORDS-1:0][DATA_W-1:0] bl_mat;
   logic [2:0][DATA_W-1:0]           sk_pos, sk_nrm;
   logic [2:0][DATA_W-1:0]           wd_pos, wd_nrm;
   ctl_type       c1a_ff, c1b_ff, c2a_ff;
   logic          rsp_valid_ff;
   logic [MAT_WORDS-1:0][DATA_W-1:0] world_ff, normal_ff;

   // register file: one bit at word 0
   assign csr_reg    = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_reg == REG_SKIN_ENABLE) ? {31'b0, skin_enable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         skin_enable_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_reg == REG_SKIN_ENABLE) begin
         skin_enable_ff <= csr_pwdata[0];
      end
   end

   // front: classify the word and park it in the queue
   lbs_front #(.JOINT_COUNT(JOINT_COUNT)) u_front (
      .skin_enable (skin_enable_ff),
      .req_data    (req_tdata),
      .req_kind    (req_tuser),
      .item        (front_item)
   );

   assign req_tready = !q_full;

   // whole back pipeline advances together; it holds only while a result waits
   assign en = !rsp_valid_ff || rsp_tready;

   lbs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (front_item),
      .full      (q_full),
      .pop       (en),
      .not_empty (q_valid),
      .head_item (q_item)
   );

   // joint loads write and vertices read the banks at the same stage,
   // so a vertex always sees every load that came before it
   lbs_blend #(.JOINT_COUNT(JOINT_COUNT), .FRAC_BITS(FRAC_BITS)) u_blend (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (q_valid),
      .in_item  (q_item),
      .out_ctl  (bl_ctl),
      .out_pos  (bl_pos),
      .out_nrm  (bl_nrm),
      .out_mat  (bl_mat)
   );

   lbs_xform #(.FRAC_BITS(FRAC_BITS)) u_skin (
      .clock   (clock),
      .en      (en),
      .vec_pos (bl_pos),
      .vec_nrm (bl_nrm),
      .mat_pos (bl_mat),
      .mat_nrm (bl_mat),
      .res_pos (sk_pos),
      .res_nrm (sk_nrm)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c1a_ff       <= '0;
         c1b_ff       <= '0;
         c2a_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         c1a_ff       <= bl_ctl;
         c1b_ff       <= c1a_ff;
         c2a_ff       <= c1b_ff;
         rsp_valid_ff <= c2a_ff.vld && c2a_ff.is_vtx;
      end
   end

   // world and normal matrices are written where the world unit reads them,
   // which keeps loads and vertices in order
   always_ff @(posedge clock) begin
      if (en && c1b_ff.vld) begin
         if (c1b_ff.wr_world) begin
            world_ff[c1b_ff.elem] <= c1b_ff.value;
         end
         if (c1b_ff.wr_normal) begin
            normal_ff[c1b_ff.elem] <= c1b_ff.value;
         end
      end
   end

   lbs_xform #(.FRAC_BITS(FRAC_BITS)) u_world (
      .clock   (clock),
      .en      (en),
      .vec_pos (sk_pos),
      .vec_nrm (sk_nrm),
      .mat_pos (world_ff),
      .mat_nrm (normal_ff),
      .res_pos (wd_pos),
      .res_nrm (wd_nrm)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {wd_nrm[2], wd_nrm[1], wd_nrm[0], wd_pos[2], wd_pos[1], wd_pos[0]};

   // a load word never turns into a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      en && c2a_ff.vld && !c2a_ff.is_vtx |=> !rsp_tvalid)
      else $error("load word produced a result");

   // a stalled pipeline holds the c1b and c2a control stages
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(c1b_ff) && $stable(c2a_ff))
      else $error("pipeline moved while stalled");

   // world and normal writes stay inside the twelve elements
   a_mat_elem: assert property (@(posedge clock) disable iff (reset)
      c1b_ff.vld && (c1b_ff.wr_world || c1b_ff.wr_normal) |-> c1b_ff.elem < 4'd12)
      else $error("matrix element out of range");

endmodule
`default_nettype wire

// File: sim/tb_linear_blend_skin_vertex.sv
// Testbench for linear_blend_skin_vertex: random and directed stream words, checked by a model.
`default_nettype none
module tb_linear_blend_skin_vertex
   import lbs_pkg::*;
();

   localparam int ADDR_SPACE = 3096;
   localparam int WORLD_WORD = 3072;
   localparam int NORMAL_WORD = 3084;

   // Vertex result as it appears on rsp_tdata, field by field.
   typedef struct {
      word_type pos [3];
      word_type nrm [3];
   } vertex_out_type;

   // Predicts transformed vertices and holds them until the block returns them.
   class skin_scoreboard;
      int joint_mem [ADDR_SPACE];
      int world_mat [MAT_WORDS];
      int normal_mat [MAT_WORDS];
      bit skin_on;
      int errors;
      vertex_out_type pending_vertices [$];

      function new();
         skin_on = 0;
         errors = 0;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // Row vector times 4x3 matrix; affine adds the translation row.
      function void transform(input longint v [3], input int m [MAT_WORDS], input bit affine,
                              output longint r [3]);
         longint acc;
         for (int c = 0; c < 3; c++) begin
            acc = affine ? longint'(m[9 + c]) : 0;
            for (int k = 0; k < 3; k++) acc += (v[k] * longint'(m[k * 3 + c])) >>> 16;
            r[c] = clamp32(acc);
         end
      endfunction

      function void note_word(logic op, logic [REQ_TDATA_W-1:0] d);
         logic [ADDR_W-1:0] addr;
         longint pos [3], nrm [3], rp [3], rn [3], acc [MAT_WORDS];
         int blend [MAT_WORDS];
         logic [7:0] bone;
         longint wt;
         vertex_out_type o;
         addr = d[11:0];
         if (op == OP_LOAD) begin
            if (addr < WORLD_WORD) joint_mem[addr] = d[43:12];
            else if (addr < NORMAL_WORD) world_mat[addr - WORLD_WORD] = d[43:12];
            else if (addr < ADDR_SPACE) normal_mat[addr - NORMAL_WORD] = d[43:12];
            return;
         end
         for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(d[44 + 32 * i +: 32]));
            nrm[i] = longint'($signed(d[140 + 32 * i +: 32]));
         end
         if (skin_on) begin
            for (int e = 0; e < MAT_WORDS; e++) acc[e] = 0;
            for (int b = 0; b < BONES; b++) begin
               bone = d[236 + 8 * b +: 8];
               wt = longint'(d[268 + 17 * b +: 17]);
               if (wt != 0)
                  for (int e = 0; e < MAT_WORDS; e++)
                     acc[e] += longint'(joint_mem[bone * MAT_WORDS + e]) * wt;
            end
            for (int e = 0; e < MAT_WORDS; e++) blend[e] = int'(clamp32(acc[e] >>> 16));
            transform(pos, blend, 1, rp);
            transform(nrm, blend, 0, rn);
            pos = rp;
            nrm = rn;
         end
         transform(pos, world_mat, 1, rp);
         transform(nrm, normal_mat, 0, rn);
         for (int i = 0; i < 3; i++) begin
            o.pos[i] = rp[i][31:0];
            o.nrm[i] = rn[i][31:0];
         end
         pending_vertices = {pending_vertices, o};
      endfunction

      task check_result(logic [RSP_TDATA_W-1:0] d);
         vertex_out_type o;
         if (pending_vertices.size() == 0) begin
            report($sformatf("unexpected result %h", d));
            return;
         end
         o = pending_vertices.pop_front();
         for (int i = 0; i < 3; i++) begin
            if (d[32 * i +: 32] !== o.pos[i])
               report($sformatf("pos[%0d] got %h want %h", i, d[32 * i +: 32], o.pos[i]));
            if (d[96 + 32 * i +: 32] !== o.nrm[i])
               report($sformatf("nrm[%0d] got %h want %h", i, d[96 + 32 * i +: 32], o.nrm[i]));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   skin_scoreboard sb;
   bit word_written [4096];
   bit slot_ready [256];
   int ready_slots [$];
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_cycles;

   linear_blend_skin_vertex uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Sample both handshakes at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_word(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Drive the result-side ready: a forced hold-off takes priority over random stalls.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready = 0;
         hold_off_cycles--;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Offer one word; idle first at the configured rate, then hold until it is taken.
   task send_word(logic op, logic [REQ_TDATA_W-1:0] d);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = op;
      req_tdata = d;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task load_word(int addr, logic [31:0] value);
      int s;
      send_word(OP_LOAD, {292'd0, value, addr[11:0]});
      if (addr < ADDR_SPACE) word_written[addr] = 1;
      s = addr / MAT_WORDS;
      if (addr < WORLD_WORD && !slot_ready[s]) begin
         slot_ready[s] = 1;
         for (int e = 0; e < MAT_WORDS; e++)
            if (!word_written[s * MAT_WORDS + e]) slot_ready[s] = 0;
         if (slot_ready[s]) ready_slots = {ready_slots, s};
      end
   endtask

   // Mostly moderate Q16.16 values, with some full-range and edge values mixed in.
   function logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return $signed($urandom) >>> $urandom_range(8, 20);
      endcase
   endfunction

   function logic [16:0] pick_weight();
      case ($urandom_range(0, 4))
         0: return 17'd65536;
         1: return 17'd0;
         2: return $urandom_range(0, 17'h1FFFF);
         default: return $urandom_range(0, 32768);
      endcase
   endfunction

   task send_vertex(logic [31:0] px, py, pz, nx, ny, nz, logic [31:0] bones,
                    logic [67:0] weights);
      send_word(OP_VERTEX, {weights, bones, nz, ny, nx, pz, py, px, 32'd0, 12'd0});
   endtask

   // Bones with a weight must point at a fully loaded slot; unweighted ones may point anywhere.
   task random_vertex();
      logic [31:0] bones;
      logic [67:0] weights;
      for (int b = 0; b < BONES; b++) begin
         if (ready_slots.size() > 0 && $urandom_range(0, 9) != 0) begin
            bones[8 * b +: 8] = ready_slots[$urandom_range(0, ready_slots.size() - 1)];
            weights[17 * b +: 17] = pick_weight();
         end else begin
            bones[8 * b +: 8] = $urandom;
            weights[17 * b +: 17] = slot_ready[bones[8 * b +: 8]] ? pick_weight() : 17'd0;
         end
      end
      send_vertex(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), bones, weights);
   endtask

   task load_slot(int s);
      for (int e = 0; e < MAT_WORDS; e++) load_word(s * MAT_WORDS + e, pick_value());
   endtask

   // One random stimulus step: a whole slot, a stray load, or a vertex.
   task random_step(inout int count);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         load_slot($urandom_range(0, 15) == 0 ? $urandom_range(256, 257) : $urandom_range(0, 255));
         count += 12;
      end else if (r < 15) begin
         load_word($urandom_range(0, 4095), pick_value());
         count++;
      end else begin
         random_vertex();
         count++;
      end
   endtask

   // Wait until every expected vertex has returned, then let the pipe drain.
   task drain();
      req_tvalid = 0;
      while (sb.pending_vertices.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task write_skin_enable(logic value);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = CSR_ADDR_W'(int'(REG_SKIN_ENABLE) * 4);
      csr_pwdata = {31'd0, value};
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      sb.skin_on = value;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
   endtask

   initial begin
      int count;
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tuser = OP_LOAD;
      req_tdata = '0;
      rsp_tready = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: load world and normal, then unskinned extremes.
      write_skin_enable(0);
      for (int e = 0; e < MAT_WORDS; e++) begin
         load_word(WORLD_WORD + e, (e % 4 == 0) ? 32'h0001_0000 : pick_value());
         load_word(NORMAL_WORD + e, (e % 4 == 0) ? 32'h0001_0000 : pick_value());
      end
      send_vertex(0, 0, 0, 0, 0, 0, '1, '1);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 0, 0);
      // Stray load past the normal matrix: must be ignored.
      load_word(4095, 32'hDEAD_BEEF);
      drain();

      // Directed skinning: zero weights, weights above one, unnormalized, repeated bone.
      write_skin_enable(1);
      load_slot(0);
      load_slot(255);
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0,
                  32'h1234_FF00, '0);
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000, 0, 0,
                  32'h0000_FF00, {17'h0, 17'h0, 17'h1FFFF, 17'h1FFFF});
      send_vertex(pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value(), 32'h0000_0000, {17'd0, 17'd0, 17'd20000, 17'd10000});
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 2,
                  32'hAAAA_FF00, {17'd0, 17'd0, 17'd32768, 17'd32768});
      drain();

      // Random phases across idle patterns and both register settings.
      count = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            1: begin sender_idle_pct = 75; receiver_stall_pct = 0; end
            2: begin sender_idle_pct = 0; receiver_stall_pct = 75; end
            default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
         endcase
         write_skin_enable((phase < 4) ? (phase != 1) : (phase == 5) ? 0 : 1);
         if (phase == 0) repeat (4) load_slot($urandom_range(0, 255));
         for (int n = 0; n < 128; n++) begin
            if (n == 50) begin
               // Hold the result side off long enough to back up the input.
               hold_off_cycles = 200;
               for (int k = 0; k < 20; k++) random_vertex();
               count += 20;
            end
            if (n == 90) begin
               // Pause the sender until every outstanding vertex has come back.
               req_tvalid = 0;
               while (sb.pending_vertices.size() != 0) @(negedge clock);
            end
            random_step(count);
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending_vertices.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
